/* design/prg_pkg.sv */
// Shared constants and types for the pinhole primary ray generator.
// Widths of the fixed-point datapath and the register index codes; no dependencies.
`default_nettype none

package prg_pkg;

    localparam int COORD_BITS    = 16;
    localparam int SUBPIXEL_BITS = 4;

    localparam int VEC_W  = 16;
    localparam int SCL_W  = 32;
    localparam int STEP_W = 31;
    localparam int CFG_W  = 48;
    localparam int ADDR_W = 3;

    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = 3 * VEC_W;

    localparam int PC_W  = COORD_BITS + STEP_W;
    localparam int OFS_W = PC_W - SUBPIXEL_BITS + 2;
    localparam int PRD_W = VEC_W + SCL_W;
    localparam int D_W   = 50;
    localparam int MAG_W = 49;
    localparam int CHK_W = 8;
    localparam int NCHK  = (MAG_W + CHK_W - 1) / CHK_W;
    localparam int POS_W = 6;
    localparam int NRM_W = 29;
    localparam int SQ_W  = 2 * NRM_W;
    localparam int RAD_W = 60;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 3;
    localparam int Q_W    = 15;
    localparam int DREM_W = ROOT_W + Q_W + 1;

    localparam logic [VEC_W-1:0] ONE_Q14 = 16'd16384;

    // pipeline stage map
    localparam int ST_SQ0 = 9;
    localparam int ST_DV0 = ST_SQ0 + ROOT_W + 1;
    localparam int ST_OUT = ST_DV0 + Q_W + 1;
    localparam int NSTG   = ST_OUT + 1;

    typedef enum logic [ADDR_W-1:0] {
        REG_ORIGIN  = 3'd0,
        REG_FORWARD = 3'd1,
        REG_UP      = 3'd2,
        REG_X_START = 3'd3,
        REG_X_STEP  = 3'd4,
        REG_Y_START = 3'd5,
        REG_Y_STEP  = 3'd6
    } reg_idx_t;

endpackage

`default_nettype wire

/* design/pinhole_primary_ray_generator.sv */
// Pinhole camera primary ray generator: pixel sample position in, unit direction out.
// Uses prg_pkg for widths, stage map and register codes.
//
// Usage:
//  - Configure through wr_en / wr_addr / wr_data while no transaction is in flight.
//    Index 0 camera origin (kept by the ray consumer, not used here), 1 forward,
//    2 up, 3 x start, 4 x step, 5 y start, 6 y step. Index 7 is ignored.
//  - Input stream s_*: one transaction per sample, column and row in 1/16 pixel.
//  - Output stream m_*: one transaction per input, direction x, y, z in Q1.14.
//  - Throughput is one transaction per cycle while the output is not stalled. The
//    30-stage square root (one root bit per stage) is followed by the 15-stage
//    divider (one quotient bit per stage).
//  - The whole pipeline advances together; when m_tvalid is high and m_tready
//    low, every stage holds and s_tready drops, so nothing is lost or repeated.
//  - Reset clears all stage valid bits and loads forward = +z and up = +y,
//    with all offsets and steps zero.
`default_nettype none

module pinhole_primary_ray_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [prg_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [prg_pkg::CFG_W-1:0]   wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [prg_pkg::IN_W-1:0]    s_tdata,   // pixel_col, pixel_row
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [prg_pkg::OUT_W-1:0]   m_tdata    // dir_x, dir_y, dir_z
);
    import prg_pkg::*;

    // configuration
    logic [CFG_W-1:0]         fwd_reg;
    logic [CFG_W-1:0]         up_reg;
    logic signed [SCL_W-1:0]  x0_reg;
    logic [STEP_W-1:0]        xs_reg;
    logic signed [SCL_W-1:0]  y0_reg;
    logic [STEP_W-1:0]        ys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= {ONE_Q14, 16'd0, 16'd0};
            up_reg  <= {16'd0, 16'd0, ONE_Q14} << VEC_W;
            x0_reg  <= '0;
            xs_reg  <= '0;
            y0_reg  <= '0;
            ys_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_addr))
                REG_ORIGIN:  ;
                REG_FORWARD: fwd_reg <= wr_data;
                REG_UP:      up_reg  <= wr_data;
                REG_X_START: x0_reg  <= wr_data[SCL_W-1:0];
                REG_X_STEP:  xs_reg  <= wr_data[STEP_W-1:0];
                REG_Y_START: y0_reg  <= wr_data[SCL_W-1:0];
                REG_Y_STEP:  ys_reg  <= wr_data[STEP_W-1:0];
                default:     ;
            endcase
        end
    end

    logic signed [VEC_W-1:0] f [3];
    logic signed [VEC_W-1:0] u [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            f[k] = fwd_reg[k*VEC_W +: VEC_W];
            u[k] = up_reg[k*VEC_W +: VEC_W];
        end
    end

    // pipeline control
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic            adv;

    assign adv        = !valid_reg[ST_OUT] || m_tready;
    assign s_tready   = adv;
    assign m_tvalid   = valid_reg[ST_OUT];
    assign valid_next = {valid_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    function automatic logic signed [SCL_W-1:0] sat_ofs(input logic signed [OFS_W-1:0] v);
        logic [OFS_W-SCL_W:0] top;
        top = v[OFS_W-1:SCL_W-1];
        if (&top || ~|top)
            return v[SCL_W-1:0];
        else
            return v[OFS_W-1] ? {1'b1, {(SCL_W-1){1'b0}}} : {1'b0, {(SCL_W-1){1'b1}}};
    endfunction

    function automatic logic signed [VEC_W-1:0] cross_q14(input logic signed [31:0] p,
                                                          input logic signed [31:0] q);
        logic signed [32:0] diff;
        logic signed [33:0] biased;
        logic signed [19:0] sh;
        logic [4:0]         top;
        diff   = $signed({p[31], p}) - $signed({q[31], q});
        biased = $signed({diff[32], diff}) + 34'sd8192;
        sh     = biased[33:14];
        top    = sh[19:15];
        if (&top || ~|top)
            return sh[15:0];
        else
            return sh[19] ? 16'sh8000 : 16'sh7fff;
    endfunction

    // stage 1: step products and cross-product terms
    logic [PC_W-1:0]          s1_pcx_reg, s1_pcy_reg, s1_pcx_next, s1_pcy_next;
    logic signed [31:0]       s1_cp_reg [6];
    logic signed [31:0]       s1_cp_next [6];

    always_comb
    begin
        s1_pcx_next   = PC_W'(s_tdata[COORD_BITS-1:0]) * PC_W'(xs_reg);
        s1_pcy_next   = PC_W'(s_tdata[2*COORD_BITS-1:COORD_BITS]) * PC_W'(ys_reg);
        s1_cp_next[0] = f[1] * u[2];
        s1_cp_next[1] = f[2] * u[1];
        s1_cp_next[2] = f[2] * u[0];
        s1_cp_next[3] = f[0] * u[2];
        s1_cp_next[4] = f[0] * u[1];
        s1_cp_next[5] = f[1] * u[0];
    end

    // stage 2: screen offsets and rounded cross product
    logic signed [SCL_W-1:0]  s2_xp_reg, s2_yp_reg, s2_xp_next, s2_yp_next;
    logic signed [VEC_W-1:0]  s2_c_reg [3];
    logic signed [VEC_W-1:0]  s2_c_next [3];
    logic signed [OFS_W-1:0]  ofs_x, ofs_y;

    always_comb
    begin
        ofs_x = $signed({{(OFS_W-SCL_W){x0_reg[SCL_W-1]}}, x0_reg})
              + $signed({2'b00, s1_pcx_reg[PC_W-1:SUBPIXEL_BITS]});
        ofs_y = $signed({{(OFS_W-SCL_W){y0_reg[SCL_W-1]}}, y0_reg})
              - $signed({2'b00, s1_pcy_reg[PC_W-1:SUBPIXEL_BITS]});
        s2_xp_next   = sat_ofs(ofs_x);
        s2_yp_next   = sat_ofs(ofs_y);
        s2_c_next[0] = cross_q14(s1_cp_reg[0], s1_cp_reg[1]);
        s2_c_next[1] = cross_q14(s1_cp_reg[2], s1_cp_reg[3]);
        s2_c_next[2] = cross_q14(s1_cp_reg[4], s1_cp_reg[5]);
    end

    // stage 3: up and right terms
    logic signed [PRD_W-1:0]  s3_uy_reg [3];
    logic signed [PRD_W-1:0]  s3_cx_reg [3];
    logic signed [PRD_W-1:0]  s3_uy_next [3];
    logic signed [PRD_W-1:0]  s3_cx_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_uy_next[k] = u[k] * s2_yp_reg;
            s3_cx_next[k] = s2_c_reg[k] * s2_xp_reg;
        end
    end

    // stage 4: direction sum
    logic signed [D_W-1:0]    s4_d_reg [3];
    logic signed [D_W-1:0]    s4_d_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s4_d_next[k] = $signed({{(D_W-VEC_W-24){f[k][VEC_W-1]}}, f[k], 24'd0})
                         + $signed({{(D_W-PRD_W){s3_uy_reg[k][PRD_W-1]}}, s3_uy_reg[k]})
                         + $signed({{(D_W-PRD_W){s3_cx_reg[k][PRD_W-1]}}, s3_cx_reg[k]});
        end
    end

    // stage 5: sign, magnitude, largest magnitude
    logic [MAG_W-1:0]  s5_mag_reg [3];
    logic [MAG_W-1:0]  s5_mag_next [3];
    logic [2:0]        s5_neg_reg, s5_neg_next;
    logic [MAG_W-1:0]  s5_mx_reg, s5_mx_next;
    logic [D_W-1:0]    absd [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s5_neg_next[k] = s4_d_reg[k][D_W-1];
            absd[k]        = s5_neg_next[k] ? D_W'(-s4_d_reg[k]) : D_W'(s4_d_reg[k]);
            s5_mag_next[k] = absd[k][MAG_W-1:0];
        end
        s5_mx_next = s5_mag_next[0];
        if (s5_mag_next[1] > s5_mx_next)
            s5_mx_next = s5_mag_next[1];
        if (s5_mag_next[2] > s5_mx_next)
            s5_mx_next = s5_mag_next[2];
    end

    // stage 6: leading-one search per byte
    logic [MAG_W-1:0]  s6_mag_reg [3];
    logic [2:0]        s6_neg_reg;
    logic [NCHK-1:0]   s6_any_reg, s6_any_next;
    logic [2:0]        s6_lpos_reg [NCHK];
    logic [2:0]        s6_lpos_next [NCHK];
    logic [NCHK*CHK_W-1:0] mx_pad;

    always_comb
    begin
        mx_pad = (NCHK*CHK_W)'(s5_mx_reg);
        for (int c = 0; c < NCHK; c++)
        begin
            s6_any_next[c]  = |mx_pad[c*CHK_W +: CHK_W];
            s6_lpos_next[c] = '0;
            for (int b = 0; b < CHK_W; b++)
            begin
                if (mx_pad[c*CHK_W + b])
                    s6_lpos_next[c] = 3'(b);
            end
        end
    end

    // stage 7: leading-one position
    logic [MAG_W-1:0]  s7_mag_reg [3];
    logic [2:0]        s7_neg_reg;
    logic [POS_W-1:0]  s7_pos_reg, s7_pos_next;
    logic              s7_zero_reg, s7_zero_next;

    always_comb
    begin
        s7_pos_next  = '0;
        s7_zero_next = ~|s6_any_reg;
        for (int c = 0; c < NCHK; c++)
        begin
            if (s6_any_reg[c])
                s7_pos_next = {3'(c), s6_lpos_reg[c]};
        end
    end

    // stage 8: normalize so the largest magnitude has its top bit at NRM_W-1
    logic [NRM_W-1:0]  s8_mag_reg [3];
    logic [NRM_W-1:0]  s8_mag_next [3];
    logic [2:0]        s8_neg_reg;
    logic              s8_zero_reg;
    logic [POS_W-1:0]  rsh, lsh;
    logic [MAG_W-1:0]  shv [3];

    always_comb
    begin
        rsh = s7_pos_reg - POS_W'(NRM_W - 1);
        lsh = POS_W'(NRM_W - 1) - s7_pos_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (s7_pos_reg >= POS_W'(NRM_W - 1))
                shv[k] = s7_mag_reg[k] >> rsh;
            else
                shv[k] = s7_mag_reg[k] << lsh;
            s8_mag_next[k] = shv[k][NRM_W-1:0];
        end
    end

    // stage 9: squares
    logic [SQ_W-1:0]   s9_sq_reg [3];
    logic [SQ_W-1:0]   s9_sq_next [3];
    logic [NRM_W-1:0]  s9_mag_reg [3];
    logic [2:0]        s9_neg_reg;
    logic              s9_zero_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            s9_sq_next[k] = SQ_W'(s8_mag_reg[k]) * SQ_W'(s8_mag_reg[k]);
    end

    // square root, one root bit per stage; entry 0 holds the radicand
    logic [RAD_W-1:0]  sq_rad_reg  [ROOT_W+1];
    logic [SREM_W-1:0] sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];
    logic [NRM_W-1:0]  sq_mag_reg  [ROOT_W+1][3];
    logic [2:0]        sq_neg_reg  [ROOT_W+1];
    logic              sq_zero_reg [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rad_next  [ROOT_W+1];
    logic [SREM_W-1:0] sq_rem_next  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_next [ROOT_W+1];
    logic [SREM_W-1:0] rem_sh [ROOT_W+1];
    logic [SREM_W-1:0] trial  [ROOT_W+1];
    logic              sq_ge  [ROOT_W+1];

    always_comb
    begin
        sq_rad_next[0]  = RAD_W'(s9_sq_reg[0]) + RAD_W'(s9_sq_reg[1]) + RAD_W'(s9_sq_reg[2]);
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        rem_sh[0]       = '0;
        trial[0]        = '0;
        sq_ge[0]        = 1'b0;
        for (int i = 1; i <= ROOT_W; i++)
        begin
            rem_sh[i] = {sq_rem_reg[i-1][SREM_W-3:0], sq_rad_reg[i-1][RAD_W-1:RAD_W-2]};
            trial[i]  = {1'b0, sq_root_reg[i-1], 2'b01};
            sq_ge[i]  = rem_sh[i] >= trial[i];
            sq_rem_next[i]  = sq_ge[i] ? rem_sh[i] - trial[i] : rem_sh[i];
            sq_root_next[i] = {sq_root_reg[i-1][ROOT_W-2:0], sq_ge[i]};
            sq_rad_next[i]  = sq_rad_reg[i-1] << 2;
        end
    end

    // divider, one quotient bit per stage; entry 0 holds the rounded numerator
    logic [DREM_W-1:0] dv_rem_reg [Q_W+1][3];
    logic [Q_W-1:0]    dv_q_reg   [Q_W+1][3];
    logic [ROOT_W-1:0] dv_len_reg [Q_W+1];
    logic [2:0]        dv_neg_reg [Q_W+1];
    logic              dv_zero_reg [Q_W+1];
    logic [DREM_W-1:0] dv_rem_next [Q_W+1][3];
    logic [Q_W-1:0]    dv_q_next   [Q_W+1][3];
    logic [DREM_W-1:0] dvsor [Q_W+1];
    logic              dv_ge [Q_W+1][3];

    always_comb
    begin
        dvsor[0] = '0;
        for (int k = 0; k < 3; k++)
        begin
            dv_rem_next[0][k] = DREM_W'({sq_mag_reg[ROOT_W][k], 14'd0})
                              + DREM_W'(sq_root_reg[ROOT_W] >> 1);
            dv_q_next[0][k]   = '0;
            dv_ge[0][k]       = 1'b0;
        end
        for (int j = 1; j <= Q_W; j++)
        begin
            dvsor[j] = DREM_W'(dv_len_reg[j-1]) << (Q_W - j);
            for (int k = 0; k < 3; k++)
            begin
                dv_ge[j][k]       = dv_rem_reg[j-1][k] >= dvsor[j];
                dv_rem_next[j][k] = dv_ge[j][k] ? dv_rem_reg[j-1][k] - dvsor[j]
                                                : dv_rem_reg[j-1][k];
                dv_q_next[j][k]   = {dv_q_reg[j-1][k][Q_W-2:0], dv_ge[j][k]};
            end
        end
    end

    // output stage
    logic [VEC_W-1:0] out_reg [3];
    logic [VEC_W-1:0] out_next [3];
    logic [VEC_W-1:0] qc [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qc[k] = (VEC_W'(dv_q_reg[Q_W][k]) > ONE_Q14) ? ONE_Q14 : VEC_W'(dv_q_reg[Q_W][k]);
            if (dv_zero_reg[Q_W])
                out_next[k] = '0;
            else
                out_next[k] = dv_neg_reg[Q_W][k] ? VEC_W'(-qc[k]) : qc[k];
        end
    end

    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pcx_reg <= s1_pcx_next;
            s1_pcy_reg <= s1_pcy_next;
            s1_cp_reg  <= s1_cp_next;
            s2_xp_reg  <= s2_xp_next;
            s2_yp_reg  <= s2_yp_next;
            s2_c_reg   <= s2_c_next;
            s3_uy_reg  <= s3_uy_next;
            s3_cx_reg  <= s3_cx_next;
            s4_d_reg   <= s4_d_next;
            s5_mag_reg <= s5_mag_next;
            s5_neg_reg <= s5_neg_next;
            s5_mx_reg  <= s5_mx_next;
            s6_mag_reg <= s5_mag_reg;
            s6_neg_reg <= s5_neg_reg;
            s6_any_reg <= s6_any_next;
            s6_lpos_reg <= s6_lpos_next;
            s7_mag_reg <= s6_mag_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_pos_reg <= s7_pos_next;
            s7_zero_reg <= s7_zero_next;
            s8_mag_reg <= s8_mag_next;
            s8_neg_reg <= s7_neg_reg;
            s8_zero_reg <= s7_zero_reg;
            s9_sq_reg  <= s9_sq_next;
            s9_mag_reg <= s8_mag_reg;
            s9_neg_reg <= s8_neg_reg;
            s9_zero_reg <= s8_zero_reg;

            sq_rad_reg  <= sq_rad_next;
            sq_rem_reg  <= sq_rem_next;
            sq_root_reg <= sq_root_next;
            sq_mag_reg[0]  <= s9_mag_reg;
            sq_neg_reg[0]  <= s9_neg_reg;
            sq_zero_reg[0] <= s9_zero_reg;
            for (int i = 1; i <= ROOT_W; i++)
            begin
                sq_mag_reg[i]  <= sq_mag_reg[i-1];
                sq_neg_reg[i]  <= sq_neg_reg[i-1];
                sq_zero_reg[i] <= sq_zero_reg[i-1];
            end

            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
            dv_len_reg[0]  <= sq_root_reg[ROOT_W];
            dv_neg_reg[0]  <= sq_neg_reg[ROOT_W];
            dv_zero_reg[0] <= sq_zero_reg[ROOT_W];
            for (int j = 1; j <= Q_W; j++)
            begin
                dv_len_reg[j]  <= dv_len_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
            end

            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    // a stalled output freezes every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_OUT] && !m_tready |=> $stable(valid_reg))
        else $error("pipeline moved during output stall");

    // an accepted transaction enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted transaction lost at entry");

    // unit vector components stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(out_reg[0]) >= -16'sd16384) && ($signed(out_reg[0]) <= 16'sd16384)
                  && ($signed(out_reg[1]) >= -16'sd16384) && ($signed(out_reg[1]) <= 16'sd16384)
                  && ($signed(out_reg[2]) >= -16'sd16384) && ($signed(out_reg[2]) <= 16'sd16384))
        else $error("direction component out of range");
`endif

endmodule

`default_nettype wire
